[sv/positional_list_engine_unit_defines.svh]
// assertion macros used by the checker file
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define PLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define PLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ple_pkg.sv]
// shared types and codes of the positional list engine
`default_nettype none
package ple_pkg;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_APPEND       = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 2'd1;
    localparam logic [OP_W-1:0] OP_INSERT       = 2'd2;
    localparam logic [OP_W-1:0] OP_REMOVE       = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SEEK
    } t_state;

    // broadcast to every cell in the accept cycle
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cmd;

endpackage
`default_nettype wire

[sv/ple_cell.sv]
// one list slot: holds an entry, shifts with its neighbours, carries the return lane
`default_nettype none
module ple_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 32,
    parameter int CMP_W      = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ple_pkg::t_cmd         i_cmd,
    input  wire logic [CMP_W-1:0]      i_pos,
    input  wire logic [DATA_WIDTH-1:0] i_value,
    input  wire logic [DATA_WIDTH-1:0] i_left_data,
    input  wire logic [DATA_WIDTH-1:0] i_right_data,
    input  wire logic                  i_lane_v,
    input  wire logic [DATA_WIDTH-1:0] i_lane,
    output logic      [DATA_WIDTH-1:0] o_data,
    output logic                       o_lane_v,
    output logic      [DATA_WIDTH-1:0] o_lane
);

    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_lane_v;
    logic [DATA_WIDTH-1:0] r_lane;
    logic                  w_at;
    logic                  w_above;
    logic                  w_load;

    assign w_at    = (IDX == i_pos);
    assign w_above = (IDX > i_pos);
    // the front cell hands its word straight out, so it never launches a lane word
    assign w_load  = i_cmd.rem && w_at && (INDEX != 0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (w_above) begin
                r_data <= i_left_data;
            end else if (w_at) begin
                r_data <= i_value;
            end
        end else if (i_cmd.rem && (w_at || w_above)) begin
            r_data <= i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_v <= 1'b0;
        end else begin
            r_lane_v <= w_load | i_lane_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= w_load ? r_data : i_lane;
    end

    assign o_data   = r_data;
    assign o_lane_v = r_lane_v;
    assign o_lane   = r_lane;

endmodule
`default_nettype wire

[sv/positional_list_engine_unit.sv]
// top level of the positional list engine: command decode, count, cell row, result register
//
// Usage: raise start with i_op, i_value and i_position while busy is low; the word is
// taken at that clock edge. Ops: append at back, remove front, insert at index,
// remove at index (zero-based). Each command gives exactly one result word on
// o_removed_value, o_count, o_is_empty and o_status, shown for one cycle with o_strobe.
// The receiver cannot stall; it must take the word in that cycle.
// The result is registered: o_strobe rises in the cycle after the accept for every
// command except a successful remove at index p with p > 0, for which the removed word
// travels one cell per cycle along the return lane of the cell row to the front cell.
// busy is high while that word is on its way and drops in the strobe cycle, so a new
// command may be taken in the same cycle its predecessor's result is shown.
// Throughput: one command per cycle when no remove at a non-zero index is in flight.
// Failed commands leave the list as it was and never raise busy.
// Reset (synchronous, active low) empties the list and the lane; stored entries are
// not cleared, but only entries below the count are ever read.
`default_nettype none
module positional_list_engine_unit #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic        [ple_pkg::OP_W-1:0]     i_op,
    input  wire logic signed [ple_pkg::VALUE_W-1:0]  i_value,
    input  wire logic        [ple_pkg::POS_W-1:0]    i_position,
    output logic                                     o_strobe,
    output logic signed      [ple_pkg::VALUE_W-1:0]  o_removed_value,
    output logic             [ple_pkg::COUNT_W-1:0]  o_count,
    output logic                                     o_is_empty,
    output logic             [ple_pkg::STATUS_W-1:0] o_status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;
    localparam int EXT_W = (DATA_WIDTH > ple_pkg::VALUE_W) ? DATA_WIDTH : ple_pkg::VALUE_W;

    ple_pkg::t_state r_state;
    ple_pkg::t_state n_state;

    logic [CNT_W-1:0]               r_count;
    logic [CNT_W-1:0]               n_count;
    logic                           r_strobe;
    logic                           n_strobe;
    logic [ple_pkg::VALUE_W-1:0]    r_removed;
    logic [ple_pkg::VALUE_W-1:0]    n_removed;
    logic [ple_pkg::STATUS_W-1:0]   r_status;
    logic [ple_pkg::STATUS_W-1:0]   n_status;

    logic                           w_accept;
    logic                           w_full;
    logic                           w_empty;
    logic                           w_seek;
    ple_pkg::t_cmd                  w_cmd;
    logic [CMP_W-1:0]               w_pos;
    logic [CMP_W-1:0]               w_pos_in;
    logic [CMP_W-1:0]               w_cnt;
    logic [EXT_W-1:0]               w_value_ext;
    logic [DATA_WIDTH-1:0]          w_value;
    logic signed [EXT_W-1:0]        w_front_ext;
    logic signed [EXT_W-1:0]        w_lane_ext;

    logic [DATA_WIDTH-1:0] w_data   [CAPACITY];
    logic                  w_lane_v [CAPACITY];
    logic [DATA_WIDTH-1:0] w_lane   [CAPACITY];

    assign w_accept    = start && !busy;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_pos_in    = CMP_W'(i_position);
    assign w_cnt       = CMP_W'(r_count);
    assign w_value_ext = EXT_W'($unsigned(i_value));
    assign w_value     = w_value_ext[DATA_WIDTH-1:0];
    assign w_front_ext = EXT_W'($signed(w_data[0]));
    assign w_lane_ext  = EXT_W'($signed(w_lane[0]));

    // command decode
    always_comb begin
        w_cmd    = '0;
        w_pos    = '0;
        n_status = r_status;
        if (w_accept) begin
            n_status = ple_pkg::STATUS_OK;
            case (i_op)
                ple_pkg::OP_APPEND: begin
                    if (w_full) begin
                        n_status = ple_pkg::STATUS_FULL;
                    end else begin
                        w_cmd.ins = 1'b1;
                        w_pos     = w_cnt;
                    end
                end
                ple_pkg::OP_REMOVE_FRONT: begin
                    if (w_empty) begin
                        n_status = ple_pkg::STATUS_RANGE;
                    end else begin
                        w_cmd.rem = 1'b1;
                    end
                end
                ple_pkg::OP_INSERT: begin
                    if (w_full) begin
                        n_status = ple_pkg::STATUS_FULL;
                    end else if (w_pos_in > w_cnt) begin
                        n_status = ple_pkg::STATUS_RANGE;
                    end else begin
                        w_cmd.ins = 1'b1;
                        w_pos     = w_pos_in;
                    end
                end
                default: begin
                    if (w_pos_in >= w_cnt) begin
                        n_status = ple_pkg::STATUS_RANGE;
                    end else begin
                        w_cmd.rem = 1'b1;
                        w_pos     = w_pos_in;
                    end
                end
            endcase
        end
    end

    assign w_seek = w_cmd.rem && (w_pos != '0);

    always_comb begin
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // sequencer: idle, or waiting for a word on the return lane
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ple_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_strobe  = 1'b0;
        n_removed = '0;
        busy      = 1'b0;
        case (r_state)
            ple_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (w_seek) begin
                        n_state = ple_pkg::ST_SEEK;
                    end else begin
                        n_strobe = 1'b1;
                        if (w_cmd.rem) begin
                            n_removed = w_front_ext[ple_pkg::VALUE_W-1:0];
                        end
                    end
                end
            end
            ple_pkg::ST_SEEK: begin
                busy = 1'b1;
                if (w_lane_v[0]) begin
                    n_state   = ple_pkg::ST_IDLE;
                    n_strobe  = 1'b1;
                    n_removed = w_lane_ext[ple_pkg::VALUE_W-1:0];
                end
            end
            default: begin
                n_state = ple_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_status <= ple_pkg::STATUS_OK;
        end else begin
            r_count  <= n_count;
            r_strobe <= n_strobe;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_strobe) begin
            r_removed <= n_removed;
        end
    end

    // row of cells, index 0 at the front
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        logic                  w_in_lane_v;
        logic [DATA_WIDTH-1:0] w_in_lane;

        if (g == 0) begin : g_front
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_back
            assign w_right     = '0;
            assign w_in_lane_v = 1'b0;
            assign w_in_lane   = '0;
        end else begin : g_inner
            assign w_right     = w_data[g+1];
            assign w_in_lane_v = w_lane_v[g+1];
            assign w_in_lane   = w_lane[g+1];
        end

        ple_cell #(
            .INDEX      (g),
            .DATA_WIDTH (DATA_WIDTH),
            .CMP_W      (CMP_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_pos        (w_pos),
            .i_value      (w_value),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .i_lane_v     (w_in_lane_v),
            .i_lane       (w_in_lane),
            .o_data       (w_data[g]),
            .o_lane_v     (w_lane_v[g]),
            .o_lane       (w_lane[g])
        );
    end

    assign o_strobe        = r_strobe;
    assign o_removed_value = r_removed;
    assign o_count         = w_cnt[ple_pkg::COUNT_W-1:0];
    assign o_is_empty      = w_empty;
    assign o_status        = r_status;

endmodule
`default_nettype wire

[sv/ple_checker.sv]
// port-level checks of the positional list engine and their bind
`default_nettype none
`include "positional_list_engine_unit_defines.svh"
module ple_checker #(
    parameter int CAPACITY = 64
) (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic        [ple_pkg::OP_W-1:0]     i_op,
    input wire logic                                o_strobe,
    input wire logic signed [ple_pkg::VALUE_W-1:0]  o_removed_value,
    input wire logic        [ple_pkg::COUNT_W-1:0]  o_count,
    input wire logic        [ple_pkg::STATUS_W-1:0] o_status
);

    localparam logic [ple_pkg::COUNT_W-1:0] FULL_COUNT = ple_pkg::COUNT_W'(CAPACITY);

    logic w_accept;
    assign w_accept = start && !busy;

    // every command other than a remove at index shows its result in the cycle after it is taken
    `PLE_ASSERT_NEXT(a_quick_result, i_clk, i_rst_n, w_accept && (i_op != ple_pkg::OP_REMOVE), o_strobe, "result word missing one cycle after command")
    // a failed command never hands out a value
    `PLE_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_strobe && (o_status != ple_pkg::STATUS_OK), o_removed_value == '0, "failed command returned a value")
    // a full report only comes with a full list
    `PLE_ASSERT_NOW(a_full_count, i_clk, i_rst_n, o_strobe && (o_status == ple_pkg::STATUS_FULL), o_count == FULL_COUNT, "full status with list not full")
    // busy starts only behind a command whose result is still on its way
    `PLE_ASSERT_NOW(a_busy_rise, i_clk, i_rst_n, $rose(busy), !o_strobe && ($past(i_op) == ple_pkg::OP_REMOVE), "busy rose without a pending remove")

endmodule

bind positional_list_engine_unit ple_checker #(
    .CAPACITY (CAPACITY)
) u_ple_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_op            (i_op),
    .o_strobe        (o_strobe),
    .o_removed_value (o_removed_value),
    .o_count         (o_count),
    .o_status        (o_status)
);
`default_nettype wire

[tb/testbench.sv]
// self-checking testbench of the positional list engine: directed table, then random commands
`default_nettype none
module testbench;

    localparam int LIST_CAP     = 64;
    localparam int RANDOM_ITEMS = 1550;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int EXP_DEPTH    = 4096;
    localparam int ROW_DEPTH    = 64;

    typedef struct packed {
        logic signed [ple_pkg::VALUE_W-1:0]  removed;
        logic        [ple_pkg::COUNT_W-1:0]  count;
        logic                                empty;
        logic        [ple_pkg::STATUS_W-1:0] status;
    } t_list_word;

    typedef struct packed {
        logic        [ple_pkg::OP_W-1:0]    op;
        logic signed [ple_pkg::VALUE_W-1:0] value;
        logic        [ple_pkg::POS_W-1:0]   pos;
        int                                 reps;
        logic                               typed;
        t_list_word                         want;
    } t_dir_row;

    logic                                i_clk     = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                cmd_start = 1'b0;
    logic        [ple_pkg::OP_W-1:0]     cmd_op    = ple_pkg::OP_APPEND;
    logic signed [ple_pkg::VALUE_W-1:0]  cmd_value = '0;
    logic        [ple_pkg::POS_W-1:0]    cmd_pos   = '0;
    logic                                busy;
    logic                                o_strobe;
    logic signed [ple_pkg::VALUE_W-1:0]  o_removed_value;
    logic        [ple_pkg::COUNT_W-1:0]  o_count;
    logic                                o_is_empty;
    logic        [ple_pkg::STATUS_W-1:0] o_status;

    t_list_word                         expected_words [EXP_DEPTH];
    int                                 exp_wr = 0;
    int                                 exp_rd = 0;
    t_dir_row                           dir_rows [ROW_DEPTH];
    int                                 row_count = 0;
    logic signed [ple_pkg::VALUE_W-1:0] shadow_list [LIST_CAP];
    int                                 shadow_len = 0;
    int                                 mismatches = 0;

    positional_list_engine_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .start           (cmd_start),
        .busy            (busy),
        .i_op            (cmd_op),
        .i_value         (cmd_value),
        .i_position      (cmd_pos),
        .o_strobe        (o_strobe),
        .o_removed_value (o_removed_value),
        .o_count         (o_count),
        .o_is_empty      (o_is_empty),
        .o_status        (o_status)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // applies one command to the shadow list and returns the word it should give
    function automatic t_list_word apply_command(logic [ple_pkg::OP_W-1:0] op,
                                                 logic signed [ple_pkg::VALUE_W-1:0] value,
                                                 logic [ple_pkg::POS_W-1:0] pos);
        t_list_word w;
        int p;
        int i;
        w = '0;
        w.status = ple_pkg::STATUS_OK;
        p = int'(pos);
        case (op)
            ple_pkg::OP_APPEND: begin
                if (shadow_len >= LIST_CAP) begin
                    w.status = ple_pkg::STATUS_FULL;
                end else begin
                    shadow_list[shadow_len] = value;
                    shadow_len++;
                end
            end
            ple_pkg::OP_REMOVE_FRONT: begin
                if (shadow_len == 0) begin
                    w.status = ple_pkg::STATUS_RANGE;
                end else begin
                    w.removed = shadow_list[0];
                    for (i = 0; i < shadow_len - 1; i++) shadow_list[i] = shadow_list[i + 1];
                    shadow_len--;
                end
            end
            ple_pkg::OP_INSERT: begin
                // full is checked before the index
                if (shadow_len >= LIST_CAP) begin
                    w.status = ple_pkg::STATUS_FULL;
                end else if (p > shadow_len) begin
                    w.status = ple_pkg::STATUS_RANGE;
                end else begin
                    for (i = shadow_len; i > p; i--) shadow_list[i] = shadow_list[i - 1];
                    shadow_list[p] = value;
                    shadow_len++;
                end
            end
            default: begin
                if (p >= shadow_len) begin
                    w.status = ple_pkg::STATUS_RANGE;
                end else begin
                    w.removed = shadow_list[p];
                    for (i = p; i < shadow_len - 1; i++) shadow_list[i] = shadow_list[i + 1];
                    shadow_len--;
                end
            end
        endcase
        w.count = ple_pkg::COUNT_W'(shadow_len);
        w.empty = (shadow_len == 0);
        return w;
    endfunction

    function automatic logic [ple_pkg::OP_W-1:0] pick_op(int add_pct);
        if ($urandom_range(99) < add_pct) begin
            return $urandom_range(1) ? ple_pkg::OP_APPEND : ple_pkg::OP_INSERT;
        end
        return $urandom_range(1) ? ple_pkg::OP_REMOVE_FRONT : ple_pkg::OP_REMOVE;
    endfunction

    function automatic logic signed [ple_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0:       return '0;
                1:       return '1;
                2:       return {1'b1, {(ple_pkg::VALUE_W-1){1'b0}}};
                default: return {1'b0, {(ple_pkg::VALUE_W-1){1'b1}}};
            endcase
        end
        return $urandom();
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s got %h want %h", what, got, want);
        mismatches++;
    endtask

    task automatic add_row(logic [ple_pkg::OP_W-1:0] op,
                           logic signed [ple_pkg::VALUE_W-1:0] value,
                           logic [ple_pkg::POS_W-1:0] pos, int reps, logic typed,
                           logic signed [ple_pkg::VALUE_W-1:0] rv,
                           logic [ple_pkg::COUNT_W-1:0] cnt,
                           logic [ple_pkg::STATUS_W-1:0] st);
        t_dir_row r;
        r.op           = op;
        r.value        = value;
        r.pos          = pos;
        r.reps         = reps;
        r.typed        = typed;
        r.want.removed = rv;
        r.want.count   = cnt;
        r.want.empty   = (cnt == 0);
        r.want.status  = st;
        dir_rows[row_count] = r;
        row_count++;
    endtask

    // holds the command until the block takes it, then may idle a little
    task automatic send_command(logic [ple_pkg::OP_W-1:0] op,
                                logic signed [ple_pkg::VALUE_W-1:0] value,
                                logic [ple_pkg::POS_W-1:0] pos, logic typed,
                                t_list_word want, logic allow_idle);
        t_list_word pred;
        cmd_start <= 1'b1;
        cmd_op    <= op;
        cmd_value <= value;
        cmd_pos   <= pos;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = apply_command(op, value, pos);
        expected_words[exp_wr] = typed ? want : pred;
        exp_wr++;
        if (allow_idle && $urandom_range(99) < 34) begin
            // junk on the fields while start is low
            cmd_start <= 1'b0;
            cmd_op    <= ple_pkg::OP_W'($urandom());
            cmd_value <= $urandom();
            cmd_pos   <= ple_pkg::POS_W'($urandom());
            @(posedge i_clk);
            while ($urandom_range(99) < 34) @(posedge i_clk);
        end
    endtask

    initial begin
        int k;
        int n;
        int r;
        int add_pct;
        logic [ple_pkg::OP_W-1:0] op;
        logic signed [ple_pkg::VALUE_W-1:0] value;
        logic [ple_pkg::POS_W-1:0] pos;

        add_pct = 50;
        add_row(ple_pkg::OP_REMOVE_FRONT, 0, 0, 1, 1, 0, 0, ple_pkg::STATUS_RANGE);
        add_row(ple_pkg::OP_REMOVE, 0, 0, 1, 1, 0, 0, ple_pkg::STATUS_RANGE);
        add_row(ple_pkg::OP_INSERT, 1, 1, 1, 1, 0, 0, ple_pkg::STATUS_RANGE);
        add_row(ple_pkg::OP_INSERT, 32'sh8000_0000, 0, 1, 1, 0, 1, ple_pkg::STATUS_OK);
        add_row(ple_pkg::OP_APPEND, 32'sh7fff_ffff, 0, 1, 1, 0, 2, ple_pkg::STATUS_OK);
        add_row(ple_pkg::OP_APPEND, -1, 7'h7f, 1, 1, 0, 3, ple_pkg::STATUS_OK);
        // insert at the count acts as an append
        add_row(ple_pkg::OP_INSERT, 0, 3, 1, 0, 0, 0, ple_pkg::STATUS_OK);
        add_row(ple_pkg::OP_INSERT, 32'sh1234_5678, 1, 1, 0, 0, 0, ple_pkg::STATUS_OK);
        add_row(ple_pkg::OP_REMOVE, 0, 5, 1, 1, 0, 5, ple_pkg::STATUS_RANGE);
        add_row(ple_pkg::OP_REMOVE, 0, 7'h7f, 1, 1, 0, 5, ple_pkg::STATUS_RANGE);
        add_row(ple_pkg::OP_REMOVE, 0, 4, 1, 0, 0, 0, ple_pkg::STATUS_OK);
        add_row(ple_pkg::OP_REMOVE, 0, 1, 1, 0, 0, 0, ple_pkg::STATUS_OK);
        add_row(ple_pkg::OP_REMOVE_FRONT, 0, 0, 1, 0, 0, 0, ple_pkg::STATUS_OK);
        add_row(ple_pkg::OP_APPEND, 32'sh5a5a_a5a5, 0, 62, 0, 0, 0, ple_pkg::STATUS_OK);
        add_row(ple_pkg::OP_APPEND, 7, 0, 1, 1, 0, 64, ple_pkg::STATUS_FULL);
        add_row(ple_pkg::OP_INSERT, 7, 100, 1, 1, 0, 64, ple_pkg::STATUS_FULL);
        add_row(ple_pkg::OP_INSERT, 7, 0, 1, 1, 0, 64, ple_pkg::STATUS_FULL);
        add_row(ple_pkg::OP_REMOVE, 0, 63, 1, 0, 0, 0, ple_pkg::STATUS_OK);
        add_row(ple_pkg::OP_INSERT, -1, 63, 1, 0, 0, 0, ple_pkg::STATUS_OK);
        add_row(ple_pkg::OP_REMOVE, 0, 64, 1, 1, 0, 64, ple_pkg::STATUS_RANGE);
        add_row(ple_pkg::OP_REMOVE, 0, 0, 1, 0, 0, 0, ple_pkg::STATUS_OK);
        add_row(ple_pkg::OP_REMOVE_FRONT, 0, 0, 64, 0, 0, 0, ple_pkg::STATUS_OK);
        add_row(ple_pkg::OP_REMOVE_FRONT, 0, 0, 1, 1, 0, 0, ple_pkg::STATUS_RANGE);
        add_row(ple_pkg::OP_INSERT, 0, 0, 1, 1, 0, 1, ple_pkg::STATUS_OK);

        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;

        for (r = 0; r < row_count; r++) begin
            for (k = 0; k < dir_rows[r].reps; k++) begin
                send_command(dir_rows[r].op, dir_rows[r].value + ple_pkg::VALUE_W'(k),
                             dir_rows[r].pos, dir_rows[r].typed, dir_rows[r].want, 1'b1);
            end
        end

        // phases that fill, churn and drain the list in turn
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ((n / 100) % 3)
                    0:       add_pct = 85;
                    1:       add_pct = 50;
                    default: add_pct = 15;
                endcase
            end
            op    = pick_op(add_pct);
            value = pick_value();
            if ($urandom_range(9) == 0) begin
                pos = ple_pkg::POS_W'($urandom_range(127));
            end else if (op == ple_pkg::OP_INSERT) begin
                pos = ple_pkg::POS_W'($urandom_range(shadow_len));
            end else if (shadow_len > 0) begin
                pos = ple_pkg::POS_W'($urandom_range(shadow_len - 1));
            end else begin
                pos = '0;
            end
            send_command(op, value, pos, 1'b0, '0, !(n >= 600 && n < 900));
        end
        cmd_start <= 1'b0;

        while (exp_rd != exp_wr) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    always @(posedge i_clk) begin : check_words
        t_list_word want;
        if (rst_n) begin
            if (o_strobe === 1'b1) begin
                if (exp_rd == exp_wr) begin
                    report_mismatch("result word with nothing outstanding",
                                    o_removed_value, 0);
                end else begin
                    want = expected_words[exp_rd];
                    exp_rd++;
                    if (o_removed_value !== want.removed)
                        report_mismatch("removed_value", o_removed_value, want.removed);
                    if (o_count !== want.count)
                        report_mismatch("count", 32'(o_count), 32'(want.count));
                    if (o_is_empty !== want.empty)
                        report_mismatch("is_empty", 32'(o_is_empty), 32'(want.empty));
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                end
            end else if (o_strobe !== 1'b0) begin
                report_mismatch("strobe unknown", 32'(o_strobe), 0);
            end
        end
    end

    // ends the run when nothing has moved for too long
    initial begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_start && busy === 1'b0) || o_strobe === 1'b1) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
